### rtl/tsae_pkg.sv
// tsae_pkg: shared constants, command and cell codes, beat types for the automaton engine
// no dependencies; imported by tsae_bank, tsae_row_rule and three_state_automaton_engine_top

package tsae_pkg;

    // default lattice size
    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_MAX_COLS = 64;

    // field widths
    localparam int CMD_W  = 2;
    localparam int ROW_W  = 6;
    localparam int COL_W  = 6;
    localparam int CELL_W = 2;
    localparam int SIZE_W = 7;

    // smallest in-use size along either axis
    localparam int MIN_SIZE = 3;

    // commands
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STEP  = 2'd2;

    // cell states
    localparam logic [CELL_W-1:0] CELL_OFF   = 2'd0;
    localparam logic [CELL_W-1:0] CELL_ON    = 2'd1;
    localparam logic [CELL_W-1:0] CELL_DYING = 2'd2;

    // an off cell with exactly this many on neighbors turns on
    localparam logic [3:0] BIRTH_COUNT = 4'd2;

    // configuration port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam logic [1:0] REG_ROWS = 2'd0;
    localparam logic [1:0] REG_COLS = 2'd1;
    localparam logic [1:0] REG_WRAP = 2'd2;

    localparam logic [SIZE_W-1:0] ROWS_RESET = 7'd64;
    localparam logic [SIZE_W-1:0] COLS_RESET = 7'd64;
    localparam logic              WRAP_RESET = 1'b1;

    // command beat
    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [CELL_W-1:0] cell_value;
    } tsae_request_t;

    // result beat
    typedef struct packed {
        logic [CELL_W-1:0] read_value;
        logic [CMD_W-1:0]  command_done;
    } tsae_response_t;

    // per-row control for the update lanes
    typedef struct packed {
        logic wrap;
        logic active;
    } tsae_row_ctl_t;

endpackage

### rtl/tsae_bank.sv
// tsae_bank: one lattice bank, one row of cells per word, synchronous read
// depends on tsae_pkg for default sizes

module tsae_bank
    import tsae_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_ROWS,
    parameter int WIDTH = CELL_W * DEF_MAX_COLS
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/tsae_row_rule.sv
// tsae_row_rule: one lane per column, computes the next generation of one lattice row
// depends on tsae_pkg for cell codes, birth count and the row control struct

module tsae_row_rule
    import tsae_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS
)
(
    input  logic [MAX_COLS-1:0][CELL_W-1:0] above,
    input  logic [MAX_COLS-1:0][CELL_W-1:0] mid,
    input  logic [MAX_COLS-1:0][CELL_W-1:0] below,
    input  logic [$clog2(MAX_COLS)-1:0]     col_last,
    input  tsae_row_ctl_t                   ctl,
    output logic [MAX_COLS-1:0][CELL_W-1:0] next_row
);

    localparam int COL_AW = $clog2(MAX_COLS);

    logic [CELL_W-1:0] above_last;
    logic [CELL_W-1:0] mid_last;
    logic [CELL_W-1:0] below_last;

    // cells of the last in-use column, the left neighbors of column 0 when wrapping
    assign above_last = above[col_last];
    assign mid_last   = mid[col_last];
    assign below_last = below[col_last];

    // one lane per column
    always_comb
    begin
        logic [CELL_W-1:0] nb [8];
        logic [3:0]        count;
        logic              first_col;
        logic              last_col;
        logic              lane_active;

        for (int c = 0; c < MAX_COLS; c++)
        begin
            first_col   = (c == 0);
            last_col    = (COL_AW'(c) == col_last);
            lane_active = ctl.active && (COL_AW'(c) <= col_last);

            // straight above and below
            nb[0] = above[c];
            nb[1] = below[c];

            // left neighbors
            if (first_col)
            begin
                nb[2] = ctl.wrap ? above_last : CELL_OFF;
                nb[3] = ctl.wrap ? mid_last   : CELL_OFF;
                nb[4] = ctl.wrap ? below_last : CELL_OFF;
            end
            else
            begin
                nb[2] = above[c-1];
                nb[3] = mid[c-1];
                nb[4] = below[c-1];
            end

            // right neighbors
            if (last_col)
            begin
                nb[5] = ctl.wrap ? above[0] : CELL_OFF;
                nb[6] = ctl.wrap ? mid[0]   : CELL_OFF;
                nb[7] = ctl.wrap ? below[0] : CELL_OFF;
            end
            else if (c < MAX_COLS - 1)
            begin
                nb[5] = above[c+1];
                nb[6] = mid[c+1];
                nb[7] = below[c+1];
            end
            else
            begin
                nb[5] = CELL_OFF;
                nb[6] = CELL_OFF;
                nb[7] = CELL_OFF;
            end

            // count on neighbors, dying ones do not count
            count = '0;
            for (int k = 0; k < 8; k++)
            begin
                count = count + {3'd0, (nb[k] == CELL_ON)};
            end

            // state rule, cells outside the in-use region keep their value
            if (!lane_active)
            begin
                next_row[c] = mid[c];
            end
            else
            begin
                case (mid[c])
                    CELL_DYING: next_row[c] = CELL_OFF;
                    CELL_ON:    next_row[c] = CELL_DYING;
                    default:    next_row[c] = (count == BIRTH_COUNT) ? CELL_ON : CELL_OFF;
                endcase
            end
        end
    end

endmodule

### rtl/three_state_automaton_engine_top.sv
// three_state_automaton_engine_top: three-state lattice engine with command and apb ports
// depends on tsae_pkg, tsae_bank and tsae_row_rule
//
// channel   | direction | handshake                  | beat
// ----------+-----------+----------------------------+---------------------------------------
// command   | in        | start high while busy low  | request  (command, row, col, cell_value)
// result    | out       | done high for one cycle    | response (read_value, command_done)
// config    | in        | apb write: psel & penable  | pwdata at paddr 0 rows, 4 cols, 8 wrap
//
// cell write and cell read: a bank read of the row word, then the result; a write also does
// the read-modify-write of that row word
// generation: the row window is primed by reads, then each row takes one read from the current bank and
// one write of the updated row into the other bank, all columns done at once in lanes
// out-of-range address or unknown command: result in the cycle after accept
// after reset a clearing pass writes both banks, one row a cycle, with busy high; results are
// a strobe the receiver cannot stall

module three_state_automaton_engine_top
    import tsae_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
)
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               start,
    output logic               busy,
    input  tsae_request_t      request,

    output logic               done,
    output tsae_response_t     response,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int ROW_AW   = $clog2(MAX_ROWS);
    localparam int COL_AW   = $clog2(MAX_COLS);
    localparam int ROW_CW   = ROW_AW + 1;
    localparam int ROW_BITS = CELL_W * MAX_COLS;
    localparam int RC_W     = ($clog2(MAX_ROWS + 1) > $clog2(MAX_COLS + 1)) ?
                              $clog2(MAX_ROWS + 1) : $clog2(MAX_COLS + 1);
    localparam int CMP_W    = (RC_W > SIZE_W) ? RC_W : SIZE_W;

    localparam logic [ROW_AW-1:0] ROW_LAST_IDX = ROW_AW'(MAX_ROWS - 1);

    // control states
    localparam logic [3:0] ST_CLEAR     = 4'd0;
    localparam logic [3:0] ST_IDLE      = 4'd1;
    localparam logic [3:0] ST_CELL_RD   = 4'd2;
    localparam logic [3:0] ST_CELL_DONE = 4'd3;
    localparam logic [3:0] ST_GEN_P0    = 4'd4;
    localparam logic [3:0] ST_GEN_P1    = 4'd5;
    localparam logic [3:0] ST_GEN_P2    = 4'd6;
    localparam logic [3:0] ST_GEN_P3    = 4'd7;
    localparam logic [3:0] ST_GEN_ROW   = 4'd8;
    localparam logic [3:0] ST_GEN_NEXT  = 4'd9;

    // configuration registers
    logic [SIZE_W-1:0] rows_in_use_reg;
    logic [SIZE_W-1:0] cols_in_use_reg;
    logic              wrap_edges_reg;

    // control
    logic [3:0]        state_reg, state_next;
    logic [ROW_AW-1:0] row_cnt_reg, row_cnt_next;
    logic              bank_sel_reg, bank_sel_next;
    logic              done_reg, done_next;
    tsae_response_t    response_reg, response_next;
    tsae_request_t     req_reg;

    // row window for generations
    logic [MAX_COLS-1:0][CELL_W-1:0] above_reg;
    logic [MAX_COLS-1:0][CELL_W-1:0] mid_reg;
    logic [MAX_COLS-1:0][CELL_W-1:0] below_reg;
    logic [MAX_COLS-1:0][CELL_W-1:0] row0_reg;

    // bank ports
    logic [ROW_AW-1:0]   rd_addr;
    logic [ROW_AW-1:0]   wr_addr;
    logic [ROW_BITS-1:0] wr_data;
    logic [ROW_BITS-1:0] rd_data0;
    logic [ROW_BITS-1:0] rd_data1;
    logic                wr_en0;
    logic                wr_en1;
    logic                cell_wr;
    logic                gen_wr;
    logic                clear_wr;

    logic [MAX_COLS-1:0][CELL_W-1:0] now_row;
    logic [MAX_COLS-1:0][CELL_W-1:0] mod_row;
    logic [MAX_COLS-1:0][CELL_W-1:0] new_row;
    logic [MAX_COLS-1:0][CELL_W-1:0] eff_above;
    logic [MAX_COLS-1:0][CELL_W-1:0] eff_below;

    logic [CMP_W-1:0]  rows_ext, cols_ext, rows_used, cols_used;
    logic [ROW_AW-1:0] row_last;
    logic [COL_AW-1:0] col_last;
    logic              req_inside;
    logic [ROW_CW-1:0] row_ahead;
    logic [ROW_AW-1:0] rd_ahead;
    logic [CELL_W-1:0] wr_value;
    logic [ROW_AW-1:0] req_row_idx;
    logic [COL_AW-1:0] req_col_idx;
    logic              cfg_wr;
    tsae_row_ctl_t     row_ctl;

    // apb register file
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_in_use_reg <= ROWS_RESET;
            cols_in_use_reg <= COLS_RESET;
            wrap_edges_reg  <= WRAP_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_ROWS: rows_in_use_reg <= pwdata[SIZE_W-1:0];
                REG_COLS: cols_in_use_reg <= pwdata[SIZE_W-1:0];
                REG_WRAP: wrap_edges_reg  <= pwdata[0];
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_ROWS: prdata = PDATA_W'(rows_in_use_reg);
            REG_COLS: prdata = PDATA_W'(cols_in_use_reg);
            REG_WRAP: prdata = PDATA_W'(wrap_edges_reg);
            default:  prdata = '0;
        endcase
    end

    // clamp the in-use sizes between MIN_SIZE and the lattice size
    always_comb
    begin
        rows_ext = CMP_W'(rows_in_use_reg);
        cols_ext = CMP_W'(cols_in_use_reg);
        if (rows_ext < CMP_W'(MIN_SIZE))
            rows_used = CMP_W'(MIN_SIZE);
        else if (rows_ext > CMP_W'(MAX_ROWS))
            rows_used = CMP_W'(MAX_ROWS);
        else
            rows_used = rows_ext;
        if (cols_ext < CMP_W'(MIN_SIZE))
            cols_used = CMP_W'(MIN_SIZE);
        else if (cols_ext > CMP_W'(MAX_COLS))
            cols_used = CMP_W'(MAX_COLS);
        else
            cols_used = cols_ext;
    end

    assign row_last = ROW_AW'(rows_used - CMP_W'(1));
    assign col_last = COL_AW'(cols_used - CMP_W'(1));

    // address check on the incoming command
    assign req_inside = (CMP_W'(request.row) < CMP_W'(MAX_ROWS)) &&
                        (CMP_W'(request.col) < CMP_W'(MAX_COLS));

    assign req_row_idx = ROW_AW'(req_reg.row);
    assign req_col_idx = COL_AW'(req_reg.col);

    // current bank row and the cell write merged into it
    assign now_row = bank_sel_reg ? rd_data1 : rd_data0;

    assign wr_value = (req_reg.cell_value == CELL_ON || req_reg.cell_value == CELL_DYING) ?
                      req_reg.cell_value : CELL_OFF;

    always_comb
    begin
        mod_row              = now_row;
        mod_row[req_col_idx] = wr_value;
    end

    // row two ahead of the one being written, for the window refill
    assign row_ahead = {1'b0, row_cnt_reg} + ROW_CW'(2);
    assign rd_ahead  = (row_ahead < ROW_CW'(MAX_ROWS)) ? row_ahead[ROW_AW-1:0] : '0;

    // edge rows of the in-use region
    assign eff_above = (row_cnt_reg == '0 && !wrap_edges_reg) ? '0 : above_reg;
    assign eff_below = (row_cnt_reg == row_last) ? (wrap_edges_reg ? row0_reg : '0) :
                       below_reg;

    assign row_ctl.wrap   = wrap_edges_reg;
    assign row_ctl.active = (row_cnt_reg <= row_last);

    tsae_row_rule #(
        .MAX_COLS (MAX_COLS)
    ) u_row_rule (
        .above    (eff_above),
        .mid      (mid_reg),
        .below    (eff_below),
        .col_last (col_last),
        .ctl      (row_ctl),
        .next_row (new_row)
    );

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        row_cnt_next  = row_cnt_reg;
        bank_sel_next = bank_sel_reg;
        done_next     = 1'b0;
        response_next = response_reg;
        rd_addr       = '0;
        wr_addr       = '0;
        wr_data       = '0;
        cell_wr       = 1'b0;
        gen_wr        = 1'b0;
        clear_wr      = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                clear_wr = 1'b1;
                wr_addr  = row_cnt_reg;
                if (row_cnt_reg == ROW_LAST_IDX)
                begin
                    state_next   = ST_IDLE;
                    row_cnt_next = '0;
                end
                else
                begin
                    row_cnt_next = row_cnt_reg + ROW_AW'(1);
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    if ((request.command == CMD_WRITE || request.command == CMD_READ) &&
                        req_inside)
                    begin
                        state_next = ST_CELL_RD;
                    end
                    else if (request.command == CMD_STEP)
                    begin
                        state_next = ST_GEN_P0;
                    end
                    else
                    begin
                        done_next                  = 1'b1;
                        response_next.read_value   = CELL_OFF;
                        response_next.command_done = request.command;
                    end
                end
            end
            ST_CELL_RD:
            begin
                rd_addr    = req_row_idx;
                state_next = ST_CELL_DONE;
            end
            ST_CELL_DONE:
            begin
                done_next                  = 1'b1;
                response_next.command_done = req_reg.command;
                if (req_reg.command == CMD_WRITE)
                begin
                    cell_wr                  = 1'b1;
                    wr_addr                  = req_row_idx;
                    wr_data                  = mod_row;
                    response_next.read_value = CELL_OFF;
                end
                else
                begin
                    response_next.read_value = now_row[req_col_idx];
                end
                state_next = ST_IDLE;
            end
            ST_GEN_P0:
            begin
                rd_addr    = row_last;
                state_next = ST_GEN_P1;
            end
            ST_GEN_P1:
            begin
                rd_addr    = '0;
                state_next = ST_GEN_P2;
            end
            ST_GEN_P2:
            begin
                rd_addr    = ROW_AW'(1);
                state_next = ST_GEN_P3;
            end
            ST_GEN_P3:
            begin
                row_cnt_next = '0;
                state_next   = ST_GEN_ROW;
            end
            ST_GEN_ROW:
            begin
                gen_wr     = 1'b1;
                wr_addr    = row_cnt_reg;
                wr_data    = new_row;
                rd_addr    = rd_ahead;
                state_next = ST_GEN_NEXT;
            end
            ST_GEN_NEXT:
            begin
                if (row_cnt_reg == ROW_LAST_IDX)
                begin
                    bank_sel_next              = ~bank_sel_reg;
                    done_next                  = 1'b1;
                    response_next.read_value   = CELL_OFF;
                    response_next.command_done = CMD_STEP;
                    row_cnt_next               = '0;
                    state_next                 = ST_IDLE;
                end
                else
                begin
                    row_cnt_next = row_cnt_reg + ROW_AW'(1);
                    state_next   = ST_GEN_ROW;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            row_cnt_reg  <= '0;
            bank_sel_reg <= 1'b0;
            done_reg     <= 1'b0;
            response_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            row_cnt_reg  <= row_cnt_next;
            bank_sel_reg <= bank_sel_next;
            done_reg     <= done_next;
            response_reg <= response_next;
        end
    end

    // command capture and row window
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_reg <= request;
        end
        case (state_reg)
            ST_GEN_P1:
            begin
                above_reg <= now_row;
            end
            ST_GEN_P2:
            begin
                mid_reg  <= now_row;
                row0_reg <= now_row;
            end
            ST_GEN_P3:
            begin
                below_reg <= now_row;
            end
            ST_GEN_NEXT:
            begin
                above_reg <= mid_reg;
                mid_reg   <= below_reg;
                below_reg <= now_row;
            end
            default: ;
        endcase
    end

    // banks: cell ops go to the current bank, generations write the other one
    assign wr_en0 = clear_wr || (cell_wr && !bank_sel_reg) || (gen_wr && bank_sel_reg);
    assign wr_en1 = clear_wr || (cell_wr && bank_sel_reg) || (gen_wr && !bank_sel_reg);

    tsae_bank #(
        .DEPTH (MAX_ROWS),
        .WIDTH (ROW_BITS)
    ) u_bank0 (
        .clk     (clk),
        .wr_en   (wr_en0),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data0)
    );

    tsae_bank #(
        .DEPTH (MAX_ROWS),
        .WIDTH (ROW_BITS)
    ) u_bank1 (
        .clk     (clk),
        .wr_en   (wr_en1),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data1)
    );

    // outputs
    assign busy     = (state_reg != ST_IDLE);
    assign done     = done_reg;
    assign response = response_reg;

`ifndef SYNTHESIS
    // no result beat comes out of the clearing pass
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> !done_reg)
    else $error("result beat during clearing pass");

    // the bank flips only together with a generation result
    assert property (@(posedge clk) disable iff (!rst_n)
        bank_sel_reg != $past(bank_sel_reg) |-> done_reg &&
        response_reg.command_done == CMD_STEP)
    else $error("bank flip without generation result");

    // both banks are written together only while clearing
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en0 && wr_en1 |-> state_reg == ST_CLEAR)
    else $error("both banks written outside clearing pass");

    // a nonzero cell value is returned only for a read
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && response_reg.read_value != CELL_OFF |->
        response_reg.command_done == CMD_READ)
    else $error("cell value returned for a command other than read");
`endif

endmodule
